### hdl/dsp_pkg.sv
// Shared constants and types for the shortest-path solver.
package dsp_pkg;

    localparam int MAX_VERTICES_DEF = 32;
    localparam int WEIGHT_BITS_DEF  = 16;
    localparam int DIST_BITS_DEF    = 24;

    localparam int VERTEX_BITS    = 5;
    localparam int WEIGHT_IN_BITS = 16;
    localparam int OUT_DIST_BITS  = 24;
    localparam int OP_BITS        = 3;

    // longest path that is ever emitted
    localparam int MAXRES = 32;

    typedef logic [OP_BITS-1:0] t_op;

    localparam t_op OP_CLEAR = 3'd0;
    localparam t_op OP_ADD   = 3'd1;
    localparam t_op OP_SOLVE = 3'd2;
    localparam t_op OP_QUERY = 3'd3;
    localparam t_op OP_PATH  = 3'd4;

endpackage

### hdl/dijkstra_shortest_path.sv
// Single-source shortest-path solver over a weighted adjacency matrix.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+-----------------------------------------
//  command  | in        | i_valid / o_ready  | operation, from/to vertex, edge weight
//  result   | out       | o_valid / i_ready  | vertex, distance, reached, pred, status, last
//
// Clear graph sweeps the edge memory one entry per cycle, and the same sweep
// runs after reset. Solve runs one min scan plus one matrix-row relax per settled
// vertex, each through the single read port of the distance memory. Query reads
// the distance memory (S_QLD) before its beat; path walks the predecessor chain
// back (S_WALK, S_WALK2), then emits each vertex from the stack (S_EMIT, S_ELD).
// o_ready is low while any command is in flight, and a result beat holds on the
// outputs until i_ready takes it.
module dijkstra_shortest_path #(
    parameter int MAX_VERTICES = dsp_pkg::MAX_VERTICES_DEF,
    parameter int WEIGHT_BITS  = dsp_pkg::WEIGHT_BITS_DEF,
    parameter int DIST_BITS    = dsp_pkg::DIST_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  dsp_pkg::t_op                         i_operation,
    input  logic [dsp_pkg::VERTEX_BITS-1:0]      i_from_vertex,
    input  logic [dsp_pkg::VERTEX_BITS-1:0]      i_to_vertex,
    input  logic [dsp_pkg::WEIGHT_IN_BITS-1:0]   i_edge_weight,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [dsp_pkg::VERTEX_BITS-1:0]      o_vertex,
    output logic [dsp_pkg::OUT_DIST_BITS-1:0]    o_distance,
    output logic                                 o_reached,
    output logic [dsp_pkg::VERTEX_BITS-1:0]      o_predecessor,
    output logic                                 o_status,
    output logic                                 o_last
);
    import dsp_pkg::*;

    localparam int VW    = $clog2(MAX_VERTICES);
    localparam int NCELL = MAX_VERTICES * MAX_VERTICES;
    localparam int AW    = $clog2(NCELL);
    localparam int SW    = ((DIST_BITS > WEIGHT_BITS) ? DIST_BITS : WEIGHT_BITS) + 1;
    localparam int OW    = (DIST_BITS > OUT_DIST_BITS) ? DIST_BITS : OUT_DIST_BITS;
    localparam int SPW   = $clog2(MAXRES) + 1;

    localparam logic [DIST_BITS-1:0]     DMAX      = '1;
    localparam logic [SW-1:0]            DMAX_S    = SW'(DMAX);
    localparam logic [OW-1:0]            OUT_MAX_W = OW'({OUT_DIST_BITS{1'b1}});
    localparam logic [OW-1:0]            DMAX_W    = OW'(DMAX);
    localparam logic [OUT_DIST_BITS-1:0] DMAX_OUT  =
        (DMAX_W > OUT_MAX_W) ? {OUT_DIST_BITS{1'b1}} : OUT_DIST_BITS'(DMAX_W);
    localparam logic [AW:0]              MV_W      = (AW+1)'(MAX_VERTICES);
    localparam logic [VW:0]              MV_I      = (VW+1)'(MAX_VERTICES);
    localparam logic [AW:0]              LAST_CELL = (AW+1)'(NCELL - 1);
    localparam logic [SPW-1:0]           SP_FULL   = SPW'(MAXRES - 1);
    localparam logic [SPW-1:0]           SP_MAX    = SPW'(MAXRES);
    localparam logic [MAX_VERTICES-1:0]  ONE_HOT0  = MAX_VERTICES'(1);

    // sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CLR   = 4'd1;
    localparam logic [3:0] S_SCAN  = 4'd2;
    localparam logic [3:0] S_RELAX = 4'd3;
    localparam logic [3:0] S_QLD   = 4'd4;
    localparam logic [3:0] S_WALK  = 4'd5;
    localparam logic [3:0] S_WALK2 = 4'd6;
    localparam logic [3:0] S_EMIT  = 4'd7;
    localparam logic [3:0] S_ELD   = 4'd8;
    localparam logic [3:0] S_WAIT  = 4'd9;

    // memories: edge matrix {present, weight}, per-vertex distance and predecessor
    logic [WEIGHT_BITS:0]   m_wt   [NCELL];
    logic [DIST_BITS-1:0]   m_dist [MAX_VERTICES];
    logic [VW-1:0]          m_came [MAX_VERTICES];
    logic [WEIGHT_BITS:0]   r_wt_q;
    logic [DIST_BITS-1:0]   r_dist_q;
    logic [VW-1:0]          r_came_q;

    logic                   wt_we;
    logic [AW-1:0]          wt_waddr;
    logic [WEIGHT_BITS:0]   wt_wdata;
    logic [AW-1:0]          wt_raddr;
    logic                   v_we;
    logic [VW-1:0]          v_waddr;
    logic [DIST_BITS-1:0]   v_wdist;
    logic [VW-1:0]          v_wcame;
    logic [VW-1:0]          v_raddr;

    // control and working registers
    logic [3:0]             r_state;
    logic [AW:0]            r_clr;
    logic [VW:0]            r_idx;
    logic                   r_pv;
    logic [VW-1:0]          r_pi;
    logic [DIST_BITS-1:0]   r_least;
    logic [VW-1:0]          r_cur;
    logic                   r_found;
    logic [AW-1:0]          r_base;
    logic [MAX_VERTICES-1:0] r_done;
    logic [MAX_VERTICES-1:0] r_touch;
    logic [VW-1:0]          r_src;
    logic [VERTEX_BITS-1:0] r_tgt;
    logic                   r_qok;
    logic [VW-1:0]          r_wcur;
    logic [SPW-1:0]         r_sp;
    logic [VW-1:0]          r_stack [MAXRES];
    logic [VW-1:0]          r_ev;

    logic                         r_o_valid;
    logic [VERTEX_BITS-1:0]       r_o_vertex;
    logic [OUT_DIST_BITS-1:0]     r_o_distance;
    logic                         r_o_reached;
    logic [VERTEX_BITS-1:0]       r_o_pred;
    logic                         r_o_status;
    logic                         r_o_last;

    // decode of the incoming beat
    logic                   accept;
    logic                   a_ok;
    logic                   b_ok;
    logic [VW-1:0]          a_idx;
    logic [VW-1:0]          b_idx;
    logic [AW-1:0]          ab_addr;

    assign o_ready = (r_state == S_IDLE);
    assign accept  = i_valid && o_ready;
    assign a_ok    = 32'(i_from_vertex) < 32'(MAX_VERTICES);
    assign b_ok    = 32'(i_to_vertex) < 32'(MAX_VERTICES);
    assign a_idx   = VW'(i_from_vertex);
    assign b_idx   = VW'(i_to_vertex);
    assign ab_addr = AW'((AW+1)'(a_idx) * MV_W + (AW+1)'(b_idx));

    // scan: unvisited vertex with strictly smaller finite distance wins, so ties
    // keep the lower vertex number
    logic [DIST_BITS-1:0]   eff_dist;
    logic                   scan_hit;
    assign eff_dist = r_touch[r_pi] ? r_dist_q : DMAX;
    assign scan_hit = r_pv && !r_done[r_pi] && (eff_dist < r_least);

    // relax: saturating add of settled distance and edge weight, strict improvement
    logic [SW-1:0]          cand_sum;
    logic [DIST_BITS-1:0]   cand;
    logic                   relax_hit;
    assign cand_sum  = SW'(r_least) + SW'(r_wt_q[WEIGHT_BITS-1:0]);
    assign cand      = (cand_sum > DMAX_S) ? DMAX : DIST_BITS'(cand_sum);
    assign relax_hit = (r_state == S_RELAX) && r_pv && !r_done[r_pi]
                       && r_wt_q[WEIGHT_BITS] && (cand < eff_dist);

    // output view of the registered distance read
    logic [OW-1:0]            q_ext;
    logic [OUT_DIST_BITS-1:0] q_out;
    assign q_ext = OW'(r_dist_q);
    assign q_out = (q_ext > OUT_MAX_W) ? {OUT_DIST_BITS{1'b1}} : OUT_DIST_BITS'(q_ext);

    // top of the path stack
    logic [SPW-1:0]         sp_m1;
    logic [VW-1:0]          stack_top;
    assign sp_m1     = r_sp - 1'b1;
    assign stack_top = r_stack[sp_m1[SPW-2:0]];

    // memory port control
    always_comb begin
        wt_we    = 1'b0;
        wt_waddr = ab_addr;
        wt_wdata = {1'b1, WEIGHT_BITS'(i_edge_weight)};
        wt_raddr = r_base + AW'(r_idx);
        v_we     = 1'b0;
        v_waddr  = r_pi;
        v_wdist  = cand;
        v_wcame  = r_cur;
        v_raddr  = r_idx[VW-1:0];
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_operation)
                        OP_ADD: begin
                            wt_we = a_ok && b_ok;
                        end
                        OP_SOLVE: begin
                            // seed the source: distance zero, points to itself
                            v_we    = a_ok;
                            v_waddr = a_idx;
                            v_wdist = '0;
                            v_wcame = a_idx;
                        end
                        default: begin
                        end
                    endcase
                end
                v_raddr = b_idx;
            end
            S_CLR: begin
                wt_we    = 1'b1;
                wt_waddr = r_clr[AW-1:0];
                wt_wdata = '0;
            end
            S_RELAX: begin
                v_we = relax_hit;
            end
            S_WALK: begin
                v_raddr = r_wcur;
            end
            S_EMIT: begin
                v_raddr = stack_top;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wt_we) begin
            m_wt[wt_waddr] <= wt_wdata;
        end
        r_wt_q <= m_wt[wt_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (v_we) begin
            m_dist[v_waddr] <= v_wdist;
            m_came[v_waddr] <= v_wcame;
        end
        r_dist_q <= m_dist[v_raddr];
        r_came_q <= m_came[v_raddr];
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_clr     <= '0;
            r_idx     <= '0;
            r_pv      <= 1'b0;
            r_found   <= 1'b0;
            r_done    <= '0;
            r_touch   <= '0;
            r_src     <= '0;
            r_sp      <= '0;
            r_o_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        case (i_operation)
                            OP_CLEAR: begin
                                r_clr   <= '0;
                                r_state <= S_CLR;
                            end
                            OP_SOLVE: begin
                                if (a_ok) begin
                                    r_done         <= '0;
                                    r_touch        <= ONE_HOT0 << a_idx;
                                    r_src          <= a_idx;
                                    r_idx          <= '0;
                                    r_pv           <= 1'b0;
                                    r_least        <= DMAX;
                                    r_found        <= 1'b0;
                                    r_state        <= S_SCAN;
                                end
                            end
                            OP_QUERY: begin
                                r_tgt   <= i_to_vertex;
                                r_qok   <= b_ok && r_done[b_idx];
                                r_state <= S_QLD;
                            end
                            OP_PATH: begin
                                r_tgt <= i_to_vertex;
                                r_sp  <= '0;
                                if (b_ok && r_done[b_idx]) begin
                                    r_wcur  <= b_idx;
                                    r_state <= S_WALK;
                                end else begin
                                    // unreachable target: one status beat
                                    r_o_valid    <= 1'b1;
                                    r_o_vertex   <= i_to_vertex;
                                    r_o_distance <= DMAX_OUT;
                                    r_o_reached  <= 1'b0;
                                    r_o_pred     <= '0;
                                    r_o_status   <= 1'b1;
                                    r_o_last     <= 1'b1;
                                    r_state      <= S_WAIT;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == LAST_CELL) begin
                        r_state <= S_IDLE;
                    end
                end
                S_SCAN: begin
                    if (scan_hit) begin
                        r_least <= eff_dist;
                        r_cur   <= r_pi;
                        r_found <= 1'b1;
                    end
                    if (r_idx != MV_I) begin
                        r_pv  <= 1'b1;
                        r_pi  <= r_idx[VW-1:0];
                        r_idx <= r_idx + 1'b1;
                    end else begin
                        r_pv <= 1'b0;
                        if (!r_pv) begin
                            if (r_found) begin
                                // settle the winner and walk its matrix row
                                r_done[r_cur] <= 1'b1;
                                r_base  <= AW'((AW+1)'(r_cur) * MV_W);
                                r_idx   <= '0;
                                r_state <= S_RELAX;
                            end else begin
                                r_state <= S_IDLE;
                            end
                        end
                    end
                end
                S_RELAX: begin
                    if (relax_hit) begin
                        r_touch[r_pi] <= 1'b1;
                    end
                    if (r_idx != MV_I) begin
                        r_pv  <= 1'b1;
                        r_pi  <= r_idx[VW-1:0];
                        r_idx <= r_idx + 1'b1;
                    end else begin
                        r_pv <= 1'b0;
                        if (!r_pv) begin
                            r_idx   <= '0;
                            r_least <= DMAX;
                            r_found <= 1'b0;
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_QLD: begin
                    r_o_valid    <= 1'b1;
                    r_o_vertex   <= r_tgt;
                    r_o_distance <= r_qok ? q_out : DMAX_OUT;
                    r_o_reached  <= r_qok;
                    r_o_pred     <= r_qok ? VERTEX_BITS'(r_came_q) : '0;
                    r_o_status   <= !r_qok;
                    r_o_last     <= 1'b1;
                    r_state      <= S_WAIT;
                end
                S_WALK: begin
                    r_stack[r_sp[SPW-2:0]] <= r_wcur;
                    if (r_wcur == r_src) begin
                        r_sp    <= r_sp + 1'b1;
                        r_state <= S_EMIT;
                    end else if (r_sp == SP_FULL) begin
                        r_sp         <= '0;
                        r_o_valid    <= 1'b1;
                        r_o_vertex   <= r_tgt;
                        r_o_distance <= DMAX_OUT;
                        r_o_reached  <= 1'b0;
                        r_o_pred     <= '0;
                        r_o_status   <= 1'b1;
                        r_o_last     <= 1'b1;
                        r_state      <= S_WAIT;
                    end else begin
                        r_sp    <= r_sp + 1'b1;
                        r_state <= S_WALK2;
                    end
                end
                S_WALK2: begin
                    if (r_done[r_came_q]) begin
                        r_wcur  <= r_came_q;
                        r_state <= S_WALK;
                    end else begin
                        // broken chain: drop the stack and report unreachable
                        r_sp         <= '0;
                        r_o_valid    <= 1'b1;
                        r_o_vertex   <= r_tgt;
                        r_o_distance <= DMAX_OUT;
                        r_o_reached  <= 1'b0;
                        r_o_pred     <= '0;
                        r_o_status   <= 1'b1;
                        r_o_last     <= 1'b1;
                        r_state      <= S_WAIT;
                    end
                end
                S_EMIT: begin
                    r_ev    <= stack_top;
                    r_sp    <= sp_m1;
                    r_state <= S_ELD;
                end
                S_ELD: begin
                    r_o_valid    <= 1'b1;
                    r_o_vertex   <= VERTEX_BITS'(r_ev);
                    r_o_distance <= q_out;
                    r_o_reached  <= 1'b1;
                    r_o_pred     <= VERTEX_BITS'(r_came_q);
                    r_o_status   <= 1'b0;
                    r_o_last     <= (r_sp == '0);
                    r_state      <= S_WAIT;
                end
                S_WAIT: begin
                    if (i_ready) begin
                        r_o_valid <= 1'b0;
                        r_state   <= (r_sp != '0) ? S_EMIT : S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid       = r_o_valid;
    assign o_vertex      = r_o_vertex;
    assign o_distance    = r_o_distance;
    assign o_reached     = r_o_reached;
    assign o_predecessor = r_o_pred;
    assign o_status      = r_o_status;
    assign o_last        = r_o_last;

    a_valid_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_state == S_WAIT))
        else $error("result beat shown outside the wait state");

    a_relax_row_settled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RELAX) |-> r_done[r_cur])
        else $error("relaxing a row whose vertex is not settled");

    a_stack_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= SP_MAX)
        else $error("path stack overflow");

    a_more_after_nonlast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |-> (r_sp != '0))
        else $error("non-final path beat with nothing left to emit");

    a_index_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN || r_state == S_RELAX) |-> (r_idx <= MV_I))
        else $error("vertex counter past the last vertex");

endmodule

### verif/tb_dijkstra_shortest_path.sv
// Testbench for the shortest-path solver: random graphs, solves, queries and path walks.
`timescale 1ns / 100ps

module tb_dijkstra_shortest_path;
    import dsp_pkg::*;

    localparam int          NV       = 32;
    localparam logic [23:0] DMAXV    = 24'hFFFFFF;
    localparam int          N_RANDOM = 480;
    // no beat for this many cycles means the block is stuck; the limit leaves
    // plenty of margin over a clear sweep or a solve
    localparam int STALL_LIMIT = 20000;

    typedef struct packed {
        t_op        op;
        logic [4:0] src;
        logic [4:0] dst;
        logic [15:0] wgt;
        logic       hold;   // wait for all results to drain before this beat
    } cmd_t;

    typedef struct packed {
        logic [4:0]  vtx;
        logic [23:0] dist_val;
        logic        reached;
        logic [4:0]  pred;
        logic        status;
        logic        last;
    } res_t;

    logic        i_clk, i_rst_n;
    logic        i_valid, o_ready, i_ready, o_valid;
    t_op         i_operation;
    logic [4:0]  i_from_vertex, i_to_vertex;
    logic [15:0] i_edge_weight;
    logic [4:0]  o_vertex, o_predecessor;
    logic [23:0] o_distance;
    logic        o_reached, o_status, o_last;

    dijkstra_shortest_path i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_operation(i_operation), .i_from_vertex(i_from_vertex),
        .i_to_vertex(i_to_vertex), .i_edge_weight(i_edge_weight),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_vertex(o_vertex), .o_distance(o_distance), .o_reached(o_reached),
        .o_predecessor(o_predecessor), .o_status(o_status), .o_last(o_last)
    );

    always begin
        i_clk = 1'b1; #10;
        i_clk = 1'b0; #10;
    end

    // predictor state
    logic [15:0] g_wgt  [NV*NV];
    logic        g_edge [NV*NV];
    logic [23:0] g_dist [NV];
    logic [4:0]  g_from [NV];
    logic        g_done [NV];
    logic [4:0]  g_src;

    cmd_t pending_cmds[$];
    res_t expected_results[$];
    int   errors;
    int   idle_cycles;
    bit   stim_done;
    int   in_beats;     // command beats taken by the block
    int   sent_beats;   // command beats raised by the driver

    function automatic void add_cmd(input cmd_t c);
        pending_cmds.insert(pending_cmds.size(), c);
    endfunction

    function automatic void add_result(input res_t r);
        expected_results.insert(expected_results.size(), r);
    endfunction

    task automatic run_dijkstra(input logic [4:0] s);
        int i, w, cur;
        bit found;
        logic [23:0] least;
        logic [24:0] cand;
        for (i = 0; i < NV; i++) begin
            g_dist[i] = DMAXV; g_from[i] = '0; g_done[i] = 1'b0;
        end
        g_src = s;
        g_dist[s] = '0;
        g_from[s] = s;
        forever begin
            found = 0; least = DMAXV; cur = 0;
            for (i = 0; i < NV; i++)
                if (!g_done[i] && g_dist[i] < least) begin
                    least = g_dist[i]; cur = i; found = 1;
                end
            if (!found) break;
            g_done[cur] = 1'b1;
            for (w = 0; w < NV; w++) begin
                if (g_done[w] || !g_edge[cur*NV+w]) continue;
                cand = {1'b0, least} + 25'(g_wgt[cur*NV+w]);
                if (cand > 25'(DMAXV)) cand = 25'(DMAXV);
                if (cand[23:0] < g_dist[w]) begin
                    g_dist[w] = cand[23:0]; g_from[w] = cur[4:0];
                end
            end
        end
    endtask

    // update the predictor with one accepted beat and queue what it yields
    task automatic predict_results(input cmd_t c);
        logic [4:0] chain[NV];
        int n, k;
        logic [4:0] cur;
        bit ok;
        res_t r;
        case (c.op)
            OP_CLEAR: for (k = 0; k < NV*NV; k++) g_edge[k] = 1'b0;
            OP_ADD: begin
                g_wgt[c.src*NV+c.dst]  = c.wgt;
                g_edge[c.src*NV+c.dst] = 1'b1;
            end
            OP_SOLVE: run_dijkstra(c.src);
            OP_QUERY: begin
                if (!g_done[c.dst])
                    r = '{c.dst, DMAXV, 1'b0, g_from[c.dst], 1'b1, 1'b1};
                else
                    r = '{c.dst, g_dist[c.dst], 1'b1, g_from[c.dst], 1'b0, 1'b1};
                add_result(r);
            end
            OP_PATH: begin
                n = 0; ok = 0; cur = c.dst;
                if (g_done[c.dst]) begin
                    while (n < MAXRES) begin
                        chain[n] = cur;
                        n++;
                        if (cur == g_src) begin
                            ok = 1; break;
                        end
                        cur = g_from[cur];
                        if (!g_done[cur]) break;
                    end
                end
                if (!ok) begin
                    r = '{c.dst, DMAXV, 1'b0, 5'd0, 1'b1, 1'b1};
                    add_result(r);
                end else begin
                    for (k = 0; k < n; k++) begin
                        cur = chain[n-1-k];
                        r = '{cur, g_dist[cur], 1'b1, g_from[cur], 1'b0, k == n-1};
                        add_result(r);
                    end
                end
            end
            default: ;  // unused codes: drop
        endcase
    endtask

    // driver: present one beat per pending command after a random gap
    int gap;
    cmd_t cur_cmd;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            gap = $urandom_range(0, 7);
        end else if (i_valid && in_beats != sent_beats) begin
            // hold the beat until accepted
        end else if (i_valid) begin
            // the previous beat went in at the last rising edge
            i_valid <= 1'b0;
            gap = $urandom_range(0, 7);
        end else if (gap > 0) begin
            gap--;
        end else if (pending_cmds.size() > 0) begin
            if (!pending_cmds[0].hold || expected_results.size() == 0) begin
                cur_cmd = pending_cmds.pop_front();
                i_operation   <= cur_cmd.op;
                i_from_vertex <= cur_cmd.src;
                i_to_vertex   <= cur_cmd.dst;
                i_edge_weight <= cur_cmd.wgt;
                i_valid       <= 1'b1;
                sent_beats++;
            end
        end
    end

    // result side stalls at random
    int rgap;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            rgap = $urandom_range(0, 7);
        end else if (i_ready && o_valid) begin
            i_ready <= 1'b0;
            rgap = $urandom_range(0, 7);
        end else if (!i_ready) begin
            if (rgap == 0) i_ready <= 1'b1;
            else rgap--;
        end
    end

    // monitor: predict on command beats, check result beats
    res_t got, want;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            idle_cycles++;
            if (i_valid && o_ready) begin
                idle_cycles = 0;
                in_beats++;
                predict_results(cur_cmd);
            end
            if (o_valid && i_ready) begin
                idle_cycles = 0;
                got = '{o_vertex, o_distance, o_reached, o_predecessor, o_status, o_last};
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result beat %p", $time, got);
                    errors++;
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        $display("%0t: result mismatch expected %p actual %p",
                                 $time, want, got);
                        errors++;
                    end
                end
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    function automatic cmd_t mk(input t_op op, input int s, input int d, input int w);
        cmd_t c;
        c.op = op; c.src = s[4:0]; c.dst = d[4:0]; c.wgt = w[15:0]; c.hold = 1'b0;
        return c;
    endfunction

    // build a small random graph and exercise it
    task automatic add_random_scene();
        int nv, ne, k, a, b, w, wide;
        nv = $urandom_range(2, 32);
        wide = $urandom_range(0, 3);
        if ($urandom_range(0, 2) == 0) add_cmd(mk(OP_CLEAR, 0, 0, 0));
        ne = $urandom_range(1, 12);
        for (k = 0; k < ne; k++) begin
            a = $urandom_range(0, nv-1);
            b = $urandom_range(0, nv-1);
            w = wide == 0 ? $urandom_range(0, 65535) : $urandom_range(0, 100);
            add_cmd(mk(OP_ADD, a, b, w));
            if ($urandom_range(0, 1)) add_cmd(mk(OP_ADD, b, a, w));
        end
        add_cmd(mk(OP_SOLVE, $urandom_range(0, nv-1), 0, $urandom));
        for (k = 0; k < 4; k++) begin
            add_cmd(mk(OP_QUERY, $urandom, $urandom_range(0, nv-1), $urandom));
            add_cmd(mk(OP_PATH, $urandom, $urandom_range(0, nv-1), $urandom));
        end
        if ($urandom_range(0, 4) == 0)
            add_cmd(mk(t_op'($urandom_range(5, 7)), $urandom, $urandom, $urandom));
    endtask

    int k;
    cmd_t c;
    initial begin
        errors = 0; idle_cycles = 0; stim_done = 0;
        in_beats = 0; sent_beats = 0;
        for (k = 0; k < NV*NV; k++) begin
            g_wgt[k] = '0; g_edge[k] = 1'b0;
        end
        for (k = 0; k < NV; k++) begin
            g_dist[k] = DMAXV; g_from[k] = '0; g_done[k] = 1'b0;
        end
        g_src = '0;
        i_valid = 1'b0; i_ready = 1'b0;
        i_operation = OP_CLEAR; i_from_vertex = '0; i_to_vertex = '0; i_edge_weight = '0;
        i_rst_n = 1'b0;

        // directed: queries before any solve, a long heavy chain, overwrite,
        // unreachable target, clear keeping the solution, unused codes
        add_cmd(mk(OP_QUERY, 31, 31, 0));
        add_cmd(mk(OP_PATH, 0, 0, 0));
        add_cmd(mk(OP_ADD, 31, 0, 65535));
        add_cmd(mk(OP_ADD, 0, 1, 5));
        add_cmd(mk(OP_ADD, 0, 1, 3));       // overwrite weight
        add_cmd(mk(OP_ADD, 1, 2, 0));
        add_cmd(mk(OP_ADD, 0, 2, 3));       // tie: keep first
        for (k = 2; k < 30; k++)
            add_cmd(mk(OP_ADD, k, k+1, 65535)); // heavy chain toward 30
        add_cmd(mk(OP_SOLVE, 31, 0, 0));
        add_cmd(mk(OP_PATH, 0, 30, 0));
        add_cmd(mk(OP_QUERY, 0, 2, 0));
        add_cmd(mk(OP_PATH, 0, 2, 0));
        add_cmd(mk(OP_PATH, 0, 31, 0));
        c = mk(OP_CLEAR, 0, 0, 0); c.hold = 1'b1;
        add_cmd(c);
        add_cmd(mk(OP_QUERY, 0, 30, 0));
        add_cmd(mk(t_op'(3'd7), 31, 31, 65535));
        add_cmd(mk(OP_SOLVE, 5, 0, 0));
        add_cmd(mk(OP_QUERY, 0, 4, 0));
        add_cmd(mk(OP_PATH, 0, 5, 0));

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while (pending_cmds.size() < N_RANDOM) add_random_scene();
        pending_cmds[pending_cmds.size()/2].hold = 1'b1;

        wait (pending_cmds.size() == 0 && !i_valid);
        wait (expected_results.size() == 0);
        repeat (50) @(posedge i_clk);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
